>>> rtl/dcm_pkg.sv
// Shared constants, types and the min-tree helper of the dark channel minimum filter.
// No dependencies; every other file of the block but dcm_ram imports this package.

package dcm_pkg;

  // Window geometry
  localparam int WINDOW_RADIUS = 7;
  localparam int MAX_WIDTH     = 1024;
  localparam int WIN           = 2 * WINDOW_RADIUS + 1;
  localparam int LINE_ROWS     = 2 * WINDOW_RADIUS;
  localparam int WIN_LVL       = $clog2(WIN);
  localparam int WIN_P2        = 1 << WIN_LVL;

  // Field and register widths
  localparam int PIX_W        = 8;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WIDTH_W      = COL_W + 1;
  localparam int ROW_W        = $clog2((1 << CFG_HEIGHT_W) + 2 * WINDOW_RADIUS);
  localparam int LAG_W        = $clog2(WINDOW_RADIUS * (MAX_WIDTH + 1) + 1);

  // Register reset values
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Gray conversion: (R*4899 + G*9617 + B*1868 + 8192) >> 14
  localparam int COEF_R     = 4899;
  localparam int COEF_G     = 9617;
  localparam int COEF_B     = 1868;
  localparam int GRAY_ROUND = 8192;
  localparam int GRAY_SHIFT = 14;
  localparam int GRAY_SUM_W = 22;

  // Register indexes (byte address / 4)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Input word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // One line store word: gray values of the 2R rows above, lane 0 is the nearest row
  typedef logic [LINE_ROWS-1:0][PIX_W-1:0] line_word_t;

  // Values entering one window minimum
  typedef logic [WIN-1:0][PIX_W-1:0] win_t;

  // Per-step control carried down the pipeline
  typedef struct packed {
    logic             virt;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] prow;
    logic             emit;
    logic [COL_W-1:0] ocol;
    logic             last;
  } dcm_meta_t;

  // Balanced minimum over one window, padded with the neutral value 255
  function automatic logic [PIX_W-1:0] min_tree(input win_t vals);
    logic [PIX_W-1:0] t [WIN_P2];
    for (int i = 0; i < WIN_P2; i++) begin
      if (i < WIN) begin
        t[i] = vals[i];
      end else begin
        t[i] = '1;
      end
    end
    for (int l = 0; l < WIN_LVL; l++) begin
      for (int i = 0; i < (WIN_P2 >> (l + 1)); i++) begin
        t[i] = (t[2*i] < t[2*i+1]) ? t[2*i] : t[2*i+1];
      end
    end
    return t[0];
  endfunction

endpackage

>>> rtl/dcm_pix_if.sv
// Input channel of the dark channel minimum filter: valid/ready plus one pixel word.
// Depends on dcm_pkg for the field widths.

interface dcm_pix_if import dcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, output kind, output blue, output green, output red,
                  input ready);
  modport sink   (input valid, input kind, input blue, input green, input red,
                  output ready);
endinterface

>>> rtl/dcm_res_if.sv
// Result channel of the dark channel minimum filter: valid/ready plus one result word.
// Depends on dcm_pkg for the field widths.

interface dcm_res_if import dcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] dark_value;
  logic             frame_last;

  modport source (output valid, output dark_value, output frame_last, input ready);
  modport sink   (input valid, input dark_value, input frame_last, output ready);
endinterface

>>> rtl/dcm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module dcm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dark_channel_min_filter.sv
// Dark channel minimum filter: gray conversion, column minimum over a line store,
// row minimum over a shift window. Depends on dcm_pkg, dcm_pix_if, dcm_res_if, dcm_ram.
//
// Usage:
//   pix_i carries raster-order words: kind 0 is a BGR pixel, kind 1 a drain tick.
//   res_o returns one word per image pixel: the minimum gray value over the
//   15x15 window clipped to the image, and frame_last on the final pixel.
//   The APB port holds frame_width (address 0) and frame_height (address 4);
//   a write restarts the frame. Write it only while the block is idle.
// Timing:
//   One word per cycle is accepted while res_o does not stall and no missing steps
//   run. The result of pixel k is produced by the word that arrives radius*(width+1)
//   steps later (a pixel, or a drain tick once the frame is complete) and passes
//   the input register, line-store read, column minimum and row minimum to res_o.
//   When a frame has fewer pixels than radius*(width+1), the block runs the
//   missing steps itself after the last pixel, one per cycle with ready low
//   unless res_o stalls, so drain ticks then return results at once.
// Reset and stall:
//   Reset sets width 640, height 480 and an empty pipeline; the next pixel starts
//   a frame. The line store needs no clearing. When res_o stalls, the pipeline
//   closes up its bubbles and then holds; no word is lost.

module dark_channel_min_filter import dcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dcm_pix_if.sink               pix_i,
  dcm_res_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------- registers
  logic [CFG_WIDTH_W-1:0]  frame_width_q;
  logic [CFG_HEIGHT_W-1:0] frame_height_q;
  logic [WIDTH_W-1:0]      eff_w;
  logic [CFG_HEIGHT_W-1:0] eff_h;
  logic [LAG_W-1:0]        lag_val;
  logic                    cfg_wr;
  logic                    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_WIDTH_W'(RESET_WIDTH);
      frame_height_q <= CFG_HEIGHT_W'(RESET_HEIGHT);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // Zero width or height reads as 1, width above the line store as the line store size
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = WIDTH_W'(frame_width_q);
    end
    eff_h = (frame_height_q == '0) ? CFG_HEIGHT_W'(1) : frame_height_q;
  end

  // Steps between a pixel and its result
  assign lag_val = LAG_W'(WINDOW_RADIUS) * (LAG_W'(eff_w) + LAG_W'(1));

  // ---------------------------------------------------------------- pipeline enables
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  logic en_a, en_b, en_c, en_d;
  logic a_to_b, b_to_c;
  logic c_emit_q;

  assign en_d   = !d_valid_q || res_o.ready;
  assign en_c   = !c_valid_q || !c_emit_q || en_d;
  assign en_b   = !b_valid_q || en_c;
  assign en_a   = !a_valid_q || en_b;
  assign a_to_b = a_valid_q && en_b;
  assign b_to_c = b_valid_q && en_c;

  // ---------------------------------------------------------------- front counters
  logic [ROW_W-1:0]        prow_q, prow_d, cur_prow;
  logic [COL_W-1:0]        pcol_q, pcol_d, cur_pcol;
  logic [CFG_HEIGHT_W-1:0] orow_q, orow_d, cur_orow;
  logic [COL_W-1:0]        ocol_q, ocol_d, cur_ocol;
  logic [LAG_W-1:0]        lag_q, lag_d, cur_lag;
  logic                    start_q, start_d;
  logic                    in_done_q, in_done_d;

  logic      auto_busy, accept, is_pix, restart, step_drain, step_auto, step, emit;
  logic      col_wrap, ocol_wrap, last_pix;
  dcm_meta_t step_meta;

  assign auto_busy   = in_done_q && (lag_q != '0);
  assign pix_i.ready = en_a && !auto_busy;
  assign accept      = pix_i.valid && pix_i.ready;
  assign is_pix      = accept && (pix_i.kind == KIND_PIXEL);
  assign restart     = is_pix && (start_q || in_done_q);
  assign step_drain  = accept && (pix_i.kind == KIND_DRAIN) && in_done_q && (orow_q < eff_h);
  assign step_auto   = auto_busy && en_a;
  assign step        = is_pix || step_drain || step_auto;

  always_comb begin
    cur_prow = restart ? '0 : prow_q;
    cur_pcol = restart ? '0 : pcol_q;
    cur_orow = restart ? '0 : orow_q;
    cur_ocol = restart ? '0 : ocol_q;
    cur_lag  = restart ? lag_val : lag_q;

    emit      = step && (cur_lag == '0) && (cur_orow < eff_h);
    col_wrap  = (WIDTH_W'(cur_pcol) + WIDTH_W'(1)) == eff_w;
    ocol_wrap = (WIDTH_W'(cur_ocol) + WIDTH_W'(1)) == eff_w;
    last_pix  = (cur_prow == (ROW_W'(eff_h) - ROW_W'(1))) && col_wrap;

    step_meta.virt = !is_pix;
    step_meta.col  = cur_pcol;
    step_meta.prow = cur_prow;
    step_meta.emit = emit;
    step_meta.ocol = cur_ocol;
    step_meta.last = (cur_orow == (eff_h - CFG_HEIGHT_W'(1))) && ocol_wrap;

    prow_d    = prow_q;
    pcol_d    = pcol_q;
    orow_d    = orow_q;
    ocol_d    = ocol_q;
    lag_d     = lag_q;
    start_d   = start_q;
    in_done_d = in_done_q;

    if (cfg_wr) begin
      // A register write restarts the frame
      prow_d    = '0;
      pcol_d    = '0;
      orow_d    = '0;
      ocol_d    = '0;
      lag_d     = '0;
      start_d   = 1'b1;
      in_done_d = 1'b0;
    end else if (step) begin
      pcol_d  = col_wrap ? '0 : cur_pcol + COL_W'(1);
      prow_d  = col_wrap ? cur_prow + ROW_W'(1) : cur_prow;
      lag_d   = (cur_lag != '0) ? cur_lag - LAG_W'(1) : '0;
      orow_d  = cur_orow;
      ocol_d  = cur_ocol;
      if (emit) begin
        ocol_d = ocol_wrap ? '0 : cur_ocol + COL_W'(1);
        orow_d = ocol_wrap ? cur_orow + CFG_HEIGHT_W'(1) : cur_orow;
      end
      if (is_pix) begin
        start_d   = 1'b0;
        in_done_d = last_pix;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prow_q    <= '0;
      pcol_q    <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      lag_q     <= '0;
      start_q   <= 1'b1;
      in_done_q <= 1'b0;
    end else begin
      prow_q    <= prow_d;
      pcol_q    <= pcol_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
      lag_q     <= lag_d;
      start_q   <= start_d;
      in_done_q <= in_done_d;
    end
  end

  // ---------------------------------------------------------------- stage A: input register
  dcm_meta_t        a_meta_q;
  logic [PIX_W-1:0] a_blue_q, a_green_q, a_red_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_a) begin
      a_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && step) begin
      a_meta_q  <= step_meta;
      a_blue_q  <= pix_i.blue;
      a_green_q <= pix_i.green;
      a_red_q   <= pix_i.red;
    end
  end

  // Gray conversion; virtual rows past the frame read as 255
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [PIX_W-1:0]      a_gray;

  assign gray_sum = GRAY_SUM_W'(COEF_R) * GRAY_SUM_W'(a_red_q)
                  + GRAY_SUM_W'(COEF_G) * GRAY_SUM_W'(a_green_q)
                  + GRAY_SUM_W'(COEF_B) * GRAY_SUM_W'(a_blue_q)
                  + GRAY_SUM_W'(GRAY_ROUND);
  assign a_gray   = a_meta_q.virt ? '1 : gray_sum[GRAY_SHIFT +: PIX_W];

  // ---------------------------------------------------------------- line store
  line_word_t ram_rdata, line_word, new_word;
  dcm_meta_t  b_meta_q;

  dcm_ram #(
    .WIDTH (LINE_ROWS * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (b_to_c),
    .waddr_i (b_meta_q.col),
    .wdata_i (new_word),
    .re_i    (a_to_b),
    .raddr_i (a_meta_q.col),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- stage B: column minimum
  logic [PIX_W-1:0] b_gray_q;
  logic             fwd_hit_q;
  line_word_t       fwd_word_q;
  win_t             cm_vals;
  logic [PIX_W-1:0] col_min;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (en_b) begin
        b_valid_q <= a_valid_q;
      end
      // Write and read of the same column at one edge: take the word being written
      if (a_to_b) begin
        fwd_hit_q <= b_to_c && (b_meta_q.col == a_meta_q.col);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_to_b) begin
      b_meta_q   <= a_meta_q;
      b_gray_q   <= a_gray;
      fwd_word_q <= new_word;
    end
  end

  assign line_word = fwd_hit_q ? fwd_word_q : ram_rdata;
  assign new_word  = {line_word[LINE_ROWS-2:0], b_gray_q};

  // Rows above the top of the image are left out
  always_comb begin
    cm_vals[0] = b_gray_q;
    for (int k = 1; k <= LINE_ROWS; k++) begin
      cm_vals[k] = (b_meta_q.prow >= ROW_W'(k)) ? line_word[k-1] : '1;
    end
  end

  assign col_min = min_tree(cm_vals);

  // ---------------------------------------------------------------- stage C: row window
  win_t             win_q, hm_vals;
  logic [COL_W-1:0] c_ocol_q;
  logic             c_last_q;
  logic [WIN-1:0]   col_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_c) begin
      c_valid_q <= b_valid_q;
    end
  end

  // Lane 0 holds the newest column minimum (output column + radius)
  always_ff @(posedge clk_i) begin
    if (b_to_c) begin
      win_q    <= {win_q[WIN-2:0], col_min};
      c_emit_q <= b_meta_q.emit;
      c_ocol_q <= b_meta_q.ocol;
      c_last_q <= b_meta_q.last;
    end
  end

  // Columns outside the current output row are left out
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      if (j < WINDOW_RADIUS) begin
        col_ok[j] = (WIDTH_W'(c_ocol_q) + WIDTH_W'(WINDOW_RADIUS - j)) < eff_w;
      end else if (j > WINDOW_RADIUS) begin
        col_ok[j] = c_ocol_q >= COL_W'(j - WINDOW_RADIUS);
      end else begin
        col_ok[j] = 1'b1;
      end
      hm_vals[j] = col_ok[j] ? win_q[j] : '1;
    end
  end

  // ---------------------------------------------------------------- stage D: result register
  logic [PIX_W-1:0] d_dark_q;
  logic             d_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en_d) begin
      d_valid_q <= c_valid_q && c_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && c_valid_q && c_emit_q) begin
      d_dark_q <= min_tree(hm_vals);
      d_last_q <= c_last_q;
    end
  end

  assign res_o.valid      = d_valid_q;
  assign res_o.dark_value = d_dark_q;
  assign res_o.frame_last = d_last_q;

  // ---------------------------------------------------------------- assertions
  a_cols_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcol_q < COL_W'(eff_w - WIDTH_W'(1)) || pcol_q == COL_W'(eff_w - WIDTH_W'(1))) &&
    (ocol_q < COL_W'(eff_w - WIDTH_W'(1)) || ocol_q == COL_W'(eff_w - WIDTH_W'(1))))
    else $error("column counter beyond frame width");

  a_out_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (orow_q <= eff_h) && !(start_q && in_done_q))
    else $error("output row count or frame state out of range");

  a_pixel_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready && pix_i.kind == KIND_PIXEL) |=> a_valid_q)
    else $error("accepted pixel did not enter the pipeline");

  a_read_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_to_b |-> (WIDTH_W'(a_meta_q.col) < eff_w))
    else $error("line store read beyond frame width");

endmodule
